// File: src/sfd_pkg.sv
// Package for the sensor frame deframer: status codes, frame byte
// positions and the result record shared by the parser and the top level.
// No dependencies.
`default_nettype none

package sfd_pkg;

   // Frame status codes
   localparam logic [1:0] STATUS_WORKING    = 2'd0;
   localparam logic [1:0] STATUS_DONE       = 2'd1;
   localparam logic [1:0] STATUS_CHECK_ERR  = 2'd2;
   localparam logic [1:0] STATUS_MISALIGNED = 2'd3;

   // Header reset value
   localparam logic [7:0] HEADER_RESET = 8'h2A;

   // Byte positions within a frame, header counted as position one
   localparam logic [2:0] POS_HEADER = 3'd1;
   localparam logic [2:0] POS_ID     = 3'd2;
   localparam logic [2:0] POS_HIGH   = 3'd3;
   localparam logic [2:0] POS_LOW    = 3'd4;
   localparam logic [2:0] POS_CHECK  = 3'd5;

   // One result item
   typedef struct packed {
      logic [1:0]  frame_status;
      logic [7:0]  device_id;
      logic [15:0] measurement;
   } result_type;

endpackage

`default_nettype wire

// File: src/sfd_parse.sv
// Frame parser: hunt/frame state, held id and measurement bytes, and the
// per-byte result. Depends on sfd_pkg.
`default_nettype none

module sfd_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [7:0]         header_byte,
   output sfd_pkg::result_type     result
);

   logic       in_frame_ff,   in_frame_in;
   logic [2:0] byte_index_ff, byte_index_in;
   logic [7:0] id_hold_ff,    id_hold_in;
   logic [7:0] high_hold_ff,  high_hold_in;
   logic [7:0] low_hold_ff,   low_hold_in;

   logic [2:0] next_index;
   logic [7:0] part_sum;
   logic [7:0] full_sum;

   assign next_index = byte_index_ff + 3'd1;
   assign part_sum   = header_byte + id_hold_ff + high_hold_ff;
   assign full_sum   = part_sum + low_hold_ff;

   // Decode the byte against the current frame position
   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_index_in = byte_index_ff;
      id_hold_in    = id_hold_ff;
      high_hold_in  = high_hold_ff;
      low_hold_in   = low_hold_ff;
      result        = '0;
      result.frame_status = sfd_pkg::STATUS_WORKING;

      if (!in_frame_ff) begin
         // hunt: drop everything but the header
         if (rx_byte == header_byte) begin
            in_frame_in   = 1'b1;
            byte_index_in = sfd_pkg::POS_HEADER;
         end
      end else begin
         byte_index_in = next_index;
         unique case (next_index)
            sfd_pkg::POS_ID: begin
               id_hold_in = rx_byte;
            end
            sfd_pkg::POS_HIGH: begin
               high_hold_in = rx_byte;
            end
            sfd_pkg::POS_LOW: begin
               low_hold_in = rx_byte;
            end
            sfd_pkg::POS_CHECK: begin
               if (full_sum == rx_byte) begin
                  result.frame_status = sfd_pkg::STATUS_DONE;
                  result.device_id    = id_hold_ff;
                  result.measurement  = {high_hold_ff, low_hold_ff};
               end else if (rx_byte == header_byte && part_sum == low_hold_ff) begin
                  result.frame_status = sfd_pkg::STATUS_MISALIGNED;
               end else begin
                  result.frame_status = sfd_pkg::STATUS_CHECK_ERR;
               end
               in_frame_in   = 1'b0;
               byte_index_in = 3'd0;
            end
            default: begin
               // position outside the frame: end it as misaligned
               result.frame_status = sfd_pkg::STATUS_MISALIGNED;
               in_frame_in   = 1'b0;
               byte_index_in = 3'd0;
            end
         endcase
      end
   end

   // Advance the parser state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_index_ff <= 3'd0;
         id_hold_ff    <= 8'd0;
         high_hold_ff  <= 8'd0;
         low_hold_ff   <= 8'd0;
      end else if (accept) begin
         in_frame_ff   <= in_frame_in;
         byte_index_ff <= byte_index_in;
         id_hold_ff    <= id_hold_in;
         high_hold_ff  <= high_hold_in;
         low_hold_ff   <= low_hold_in;
      end
   end

endmodule

`default_nettype wire

// File: src/sensor_frame_deframer_top.sv
// Top level of the sensor frame deframer: header register, input handshake
// and the result register. Depends on sfd_pkg and sfd_parse.
//
// Usage:
//   req_* carries one received serial byte per item (valid/ready).
//   rsp_* returns exactly one result item per accepted byte: a status
//   (working, done, checksum error, misaligned) with the device id and
//   16-bit measurement, both zero unless the status is done.
//   csr_wr_en/csr_wr_data write the header byte; write only while idle.
// Timing:
//   The result of a byte is in the result register in the cycle after the
//   byte is accepted. One byte per cycle is sustained while rsp_ready
//   stays high: the parse is one short decode and an 8-bit sum of four
//   bytes between the parser state and the result register.
// Reset:
//   Synchronous, active high. The parser returns to header hunting, the
//   held bytes clear, the header byte becomes 0x2A and no result is held.
// Stall:
//   A held result stays put while rsp_ready is low; req_ready drops only
//   when a result is held and not taken in that cycle.
`default_nettype none

module sensor_frame_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_frame_status,
   output logic [7:0]       rsp_device_id,
   output logic [15:0]      rsp_measurement,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0]          header_byte_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   sfd_pkg::result_type rsp_ff;
   sfd_pkg::result_type parse_result;
   logic                accept;

   // Take a byte whenever the result register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Hold the header byte
   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= sfd_pkg::HEADER_RESET;
      end else if (csr_wr_en) begin
         header_byte_ff <= csr_wr_data;
      end
   end

   sfd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .header_byte (header_byte_ff),
      .result      (parse_result)
   );

   // Result register valid flag
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= parse_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_ff.frame_status;
   assign rsp_device_id    = rsp_ff.device_id;
   assign rsp_measurement  = rsp_ff.measurement;

endmodule

`default_nettype wire

// File: src/sfd_checker.sv
// Port-level checker for the sensor frame deframer, bound to the top level.
// Depends on sfd_pkg and sensor_frame_deframer_top.
`default_nettype none

module sfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_frame_status,
   input wire logic [7:0]  rsp_device_id,
   input wire logic [15:0] rsp_measurement
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_device_id) && $stable(rsp_measurement))
      else $error("stalled result changed");

   // Every accepted byte produces a result in the next cycle
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   // Input is never stalled while the result register is empty or drains
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with free result register");

   // Id and measurement are zero unless the frame is done
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != sfd_pkg::STATUS_DONE
         |-> rsp_device_id == 8'd0 && rsp_measurement == 16'd0)
      else $error("payload set without frame done");

endmodule

bind sensor_frame_deframer_top sfd_checker u_sfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_frame_status (rsp_frame_status),
   .rsp_device_id    (rsp_device_id),
   .rsp_measurement  (rsp_measurement)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for sensor_frame_deframer_top: directed and random byte
// streams, a byte-level frame parser predictor and an in-order result checker.
// Depends on sfd_pkg and the deframer RTL.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASE_ITEMS  = 238;
   localparam int RAND_PHASES  = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_frame_status;
   logic [7:0]  rsp_device_id;
   logic [15:0] rsp_measurement;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   sensor_frame_deframer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_status (rsp_frame_status),
      .rsp_device_id    (rsp_device_id),
      .rsp_measurement  (rsp_measurement),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Parser shadow state and the results still owed by the block
   logic [7:0]  mdl_header = sfd_pkg::HEADER_RESET;
   logic        mdl_in_frame = 1'b0;
   logic [2:0]  mdl_pos = 3'd0;
   logic [7:0]  mdl_id = 8'h00;
   logic [7:0]  mdl_high = 8'h00;
   logic [7:0]  mdl_low = 8'h00;
   sfd_pkg::result_type exp_results[$];
   int          error_count = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;

   // Advance the shadow parser by one byte and return the result it yields
   function automatic sfd_pkg::result_type deframe_byte(input logic [7:0] b);
      sfd_pkg::result_type r;
      logic [7:0] sum;
      logic [7:0] part;
      r = '0;
      r.frame_status = sfd_pkg::STATUS_WORKING;
      if (!mdl_in_frame) begin
         if (b == mdl_header) begin
            mdl_in_frame = 1'b1;
            mdl_pos = sfd_pkg::POS_HEADER;
         end
      end else begin
         mdl_pos = mdl_pos + 3'd1;
         case (mdl_pos)
            sfd_pkg::POS_ID:   mdl_id = b;
            sfd_pkg::POS_HIGH: mdl_high = b;
            sfd_pkg::POS_LOW:  mdl_low = b;
            sfd_pkg::POS_CHECK: begin
               sum  = mdl_header + mdl_id + mdl_high + mdl_low;
               part = mdl_header + mdl_id + mdl_high;
               if (sum == b) begin
                  r.frame_status = sfd_pkg::STATUS_DONE;
                  r.device_id    = mdl_id;
                  r.measurement  = {mdl_high, mdl_low};
               end else if (b == mdl_header && part == mdl_low) begin
                  r.frame_status = sfd_pkg::STATUS_MISALIGNED;
               end else begin
                  r.frame_status = sfd_pkg::STATUS_CHECK_ERR;
               end
               mdl_in_frame = 1'b0;
               mdl_pos = 3'd0;
            end
            default: begin
               // position outside the frame: end it and hunt again
               r.frame_status = sfd_pkg::STATUS_MISALIGNED;
               mdl_in_frame = 1'b0;
               mdl_pos = 3'd0;
            end
         endcase
      end
      return r;
   endfunction

   function automatic logic [7:0] frame_sum(input logic [7:0] h, input logic [7:0] id,
                                            input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] s;
      s = h + id + hi + lo;
      return s;
   endfunction

   // Mostly random bytes, with the extremes now and then
   function automatic logic [7:0] pick_byte();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 8'h00;
      if (sel == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Send one item, with a random gap at the start of most bursts
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_rx_byte = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_results.push_back(deframe_byte(value));
   endtask

   task automatic send_frame(input logic [7:0] h, input logic [7:0] id,
                             input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] chk);
      send_byte(h);
      send_byte(id);
      send_byte(hi);
      send_byte(lo);
      send_byte(chk);
   endtask

   // Hold the sender until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (exp_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_header(input logic [7:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      mdl_header = value;
   endtask

   // Hunting bytes, good frame at full scale, checksum error, misaligned frame
   task automatic test_reset_header();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(sfd_pkg::HEADER_RESET, 8'hFF, 8'hFF, 8'hFF,
                 frame_sum(sfd_pkg::HEADER_RESET, 8'hFF, 8'hFF, 8'hFF));
      send_frame(sfd_pkg::HEADER_RESET, 8'h5A, 8'h01, 8'h80,
                 frame_sum(sfd_pkg::HEADER_RESET, 8'h5A, 8'h01, 8'h80) ^ 8'h01);
      // header byte as data, then a header in the checksum slot
      send_frame(sfd_pkg::HEADER_RESET, 8'h00, 8'h00, sfd_pkg::HEADER_RESET,
                 sfd_pkg::HEADER_RESET);
      drain_results();
   endtask

   // Header at the low extreme of its range
   task automatic test_header_extremes();
      write_header(8'h00);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      drain_results();
   endtask

   // Change the header with a frame half taken: the checksum uses the new one
   task automatic test_header_mid_frame();
      send_byte(8'h00);
      send_byte(8'h12);
      drain_results();
      write_header(8'hFF);
      send_byte(8'h34);
      send_byte(8'h56);
      send_byte(frame_sum(8'hFF, 8'h12, 8'h34, 8'h56));
      drain_results();
   endtask

   // Random phases, each under its own header value
   task automatic test_random_streams();
      int sent;
      int kind;
      int n;
      logic [7:0] h;
      logic [7:0] id;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] chk;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase == 0) h = 8'hFF;
         else if (phase == 1) h = sfd_pkg::HEADER_RESET;
         else if (phase == 2) h = 8'h00;
         else h = 8'($urandom);
         write_header(h);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            id = pick_byte();
            hi = pick_byte();
            lo = pick_byte();
            if (kind < 60) begin
               send_frame(h, id, hi, lo, frame_sum(h, id, hi, lo));
               sent += 5;
            end else if (kind < 70) begin
               lo = h + id + hi;
               send_frame(h, id, hi, lo, h);
               sent += 5;
            end else if (kind < 85) begin
               chk = frame_sum(h, id, hi, lo) ^ 8'($urandom_range(1, 255));
               send_frame(h, id, hi, lo, chk);
               sent += 5;
            end else if (kind < 95) begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'($urandom));
               sent += n;
            end else begin
               // truncated frame: the next frame's bytes fill its slots
               send_byte(h);
               n = $urandom_range(1, 3);
               repeat (n) send_byte(pick_byte());
               sent += n + 1;
            end
         end
         drain_results();
      end
   endtask

   // Receiver stall pattern, switching to a randomly chosen mode at a regular interval
   int rx_mode = 0;
   int rx_tick = 0;
   int rx_stall = 0;
   always @(negedge clock) begin
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      rx_tick++;
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= (rx_tick % 4 == 0);
         default: begin
            if (rx_stall != 0) begin
               rx_stall--;
               rsp_ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 20);
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin : check_result
      sfd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d id %02h meas %04h", $time,
                     rsp_frame_status, rsp_device_id, rsp_measurement);
            error_count++;
         end else begin
            want = exp_results.pop_front();
            if (rsp_frame_status !== want.frame_status) begin
               $display("%0t: frame_status expected %0d actual %0d", $time,
                        want.frame_status, rsp_frame_status);
               error_count++;
            end
            if (rsp_device_id !== want.device_id) begin
               $display("%0t: device_id expected %02h actual %02h", $time,
                        want.device_id, rsp_device_id);
               error_count++;
            end
            if (rsp_measurement !== want.measurement) begin
               $display("%0t: measurement expected %04h actual %04h", $time,
                        want.measurement, rsp_measurement);
               error_count++;
            end
         end
      end
   end

   // End the run if no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, exp_results.size());
            $display("sensor_frame_deframer_top test failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_header();
      test_header_extremes();
      test_header_mid_frame();
      test_random_streams();
      drain_results();
      repeat (8) @(posedge clock);
      if (exp_results.size() != 0) begin
         $display("%0t: %0d expected results never came", $time, exp_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("sensor_frame_deframer_top test passed");
      end else begin
         $display("sensor_frame_deframer_top test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
src/sfd_pkg.sv
src/sfd_parse.sv
src/sensor_frame_deframer_top.sv
src/sfd_checker.sv
tb/tb_top.sv
